// ===== hdl/mbc1_bank_mapper_unit_assert.svh =====
// Assertion macros for the MBC1 bank mapper.
`ifndef MBC1_BANK_MAPPER_UNIT_ASSERT_SVH
`define MBC1_BANK_MAPPER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MBC1_ASSERT_IMP(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("mbc1: assertion failed");
`define MBC1_ASSERT_NXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("mbc1: assertion failed");
`define MBC1_ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("mbc1: assertion failed");
`else
`define MBC1_ASSERT_IMP(name, clk, rst_n, pre, post)
`define MBC1_ASSERT_NXT(name, clk, rst_n, pre, post)
`define MBC1_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ===== hdl/mbc1_pkg.sv =====
// Shared types, constants and functions of the MBC1 bank mapper.
package mbc1_pkg;

	localparam int RAM_BYTES_DEF = 32768;
	localparam int ROM_BANKS_DEF = 128;
	localparam int BANK_COUNT    = 128;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [1:0] RAM_SIZE_NONE = 2'd0;
	localparam logic [1:0] RAM_SIZE_2K   = 2'd1;
	localparam logic [1:0] RAM_SIZE_8K   = 2'd2;
	localparam logic [1:0] RAM_SIZE_32K  = 2'd3;

	localparam logic [15:0] RAM_BYTES_2K  = 16'h0800;
	localparam logic [15:0] RAM_BYTES_8K  = 16'h2000;
	localparam logic [15:0] RAM_BYTES_32K = 16'h8000;

	// control register select, address bits 14:13 within 0x0000-0x7FFF
	localparam logic [1:0] CTRL_RAM_EN   = 2'd0;
	localparam logic [1:0] CTRL_BANK_LO  = 2'd1;
	localparam logic [1:0] CTRL_BANK_HI  = 2'd2;
	localparam logic [1:0] CTRL_MODE     = 2'd3;

	localparam logic [15:0] CART_RAM_LO  = 16'hA000;
	localparam logic [15:0] CART_RAM_HI  = 16'hBFFF;
	localparam logic [3:0]  RAM_EN_KEY   = 4'hA;
	localparam logic [7:0]  OPEN_BUS     = 8'hFF;

	typedef struct packed {
		logic        ram_rd;
		logic        ram_wr;
		logic [14:0] ram_pos;
		logic [7:0]  wr_data;
		logic [7:0]  fixed_data;
		logic [20:0] rom_address;
		logic        rom_read;
		logic        ram_enabled;
	} entry_t;

	// bank number modulo ROM bank count, built by counting
	function automatic logic [BANK_COUNT-1:0][6:0] rom_mod_table(input int banks);
		logic [BANK_COUNT-1:0][6:0] t;
		logic [6:0]                 r;
		r = '0;
		for (int i = 0; i < BANK_COUNT; i++) begin
			t[i] = r;
			if (int'(r) + 1 == banks) begin
				r = '0;
			end else begin
				r = r + 7'd1;
			end
		end
		return t;
	endfunction

endpackage

// ===== hdl/mbc1_front.sv =====
// Front end: accepts accesses, updates bank state and classifies each access.
`include "mbc1_bank_mapper_unit_assert.svh"
module mbc1_front #(
	parameter int RAM_BYTES = mbc1_pkg::RAM_BYTES_DEF,
	parameter int ROM_BANKS = mbc1_pkg::ROM_BANKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_enable,
	input  logic [1:0]          cfg_write_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	input  logic [15:0]         address,
	input  logic [7:0]          write_data,
	input  logic                q_full,
	output logic                push,
	output mbc1_pkg::entry_t    entry
);

	localparam logic [15:0] RAM_CAP = 16'(RAM_BYTES);
	localparam logic [mbc1_pkg::BANK_COUNT-1:0][6:0] ROM_MOD =
		mbc1_pkg::rom_mod_table(ROM_BANKS);

	logic [1:0]  ram_size_q;
	logic [6:0]  bank_q;
	logic [6:0]  rom_win_q;
	logic [1:0]  rbank_q;
	logic        ram_en_q;
	logic        mode_q;

	logic [6:0]  bank_d;
	logic [6:0]  bank_fix;
	logic [1:0]  rbank_d;
	logic        ram_en_d;
	logic        mode_d;
	logic        bank_upd;
	logic [4:0]  low_bits;
	logic [15:0] ram_lim;
	logic [14:0] ram_pos;
	logic        in_ram;
	logic        ram_ok;
	logic        ctrl_wr;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;
	assign ctrl_wr  = push && action && !address[15];
	assign ram_pos  = {rbank_q, address[12:0]};
	assign low_bits = (write_data[4:0] == 5'd0) ? 5'd1 : write_data[4:0];

	always_comb begin
		case (ram_size_q)
			mbc1_pkg::RAM_SIZE_NONE: ram_lim = '0;
			mbc1_pkg::RAM_SIZE_2K:   ram_lim = mbc1_pkg::RAM_BYTES_2K;
			mbc1_pkg::RAM_SIZE_8K:   ram_lim = mbc1_pkg::RAM_BYTES_8K;
			mbc1_pkg::RAM_SIZE_32K:  ram_lim = mbc1_pkg::RAM_BYTES_32K;
			default:                 ram_lim = '0;
		endcase
		if (ram_lim > RAM_CAP) begin
			ram_lim = RAM_CAP;
		end
	end

	always_comb begin
		bank_d   = bank_q;
		rbank_d  = rbank_q;
		ram_en_d = ram_en_q;
		mode_d   = mode_q;
		bank_upd = 1'b0;
		if (ctrl_wr) begin
			case (address[14:13])
				mbc1_pkg::CTRL_RAM_EN: begin
					ram_en_d = (write_data[3:0] == mbc1_pkg::RAM_EN_KEY);
				end
				mbc1_pkg::CTRL_BANK_LO: begin
					bank_d   = {bank_q[6:5], low_bits};
					bank_upd = 1'b1;
				end
				mbc1_pkg::CTRL_BANK_HI: begin
					if (mode_q) begin
						rbank_d = write_data[1:0];
					end else begin
						bank_d   = {write_data[1:0], bank_q[4:0]};
						bank_upd = 1'b1;
					end
				end
				mbc1_pkg::CTRL_MODE: begin
					mode_d = write_data[0];
				end
				default: begin
					mode_d = mode_q;
				end
			endcase
		end
		bank_fix = (bank_d[4:0] == 5'd0) ? (bank_d | 7'd1) : bank_d;
	end

	always_comb begin
		in_ram = address inside {[mbc1_pkg::CART_RAM_LO:mbc1_pkg::CART_RAM_HI]};
		ram_ok = {1'b0, ram_pos} < ram_lim;

		entry.ram_rd      = !action && in_ram && ram_ok;
		entry.ram_wr      = action && in_ram && ram_ok;
		entry.ram_pos     = ram_pos;
		entry.wr_data     = write_data;
		entry.fixed_data  = action ? 8'h00 : mbc1_pkg::OPEN_BUS;
		entry.rom_read    = !action && !address[15];
		entry.ram_enabled = ram_en_d;
		if (!action && !address[15]) begin
			entry.rom_address = address[14] ? {rom_win_q, address[13:0]}
				: {7'd0, address[13:0]};
		end else begin
			entry.rom_address = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_size_q <= mbc1_pkg::RAM_SIZE_NONE;
			bank_q     <= '0;
			rom_win_q  <= 7'd1;
			rbank_q    <= '0;
			ram_en_q   <= 1'b0;
			mode_q     <= 1'b0;
		end else begin
			if (cfg_write_enable) begin
				ram_size_q <= cfg_write_data;
			end
			bank_q     <= bank_d;
			rbank_q    <= rbank_d;
			ram_en_q   <= ram_en_d;
			mode_q     <= mode_d;
			if (bank_upd) begin
				rom_win_q <= ROM_MOD[bank_fix];
			end
		end
	end

	`MBC1_ASSERT_NXT(a_mode_write, clk, arst_n, ctrl_wr && address[14:13] == mbc1_pkg::CTRL_MODE, mode_q == $past(write_data[0]))

endmodule

// ===== hdl/mbc1_queue.sv =====
// Two-entry queue between the front and back ends.
`include "mbc1_bank_mapper_unit_assert.svh"
module mbc1_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mbc1_pkg::entry_t push_entry,
	input  logic             pop,
	output mbc1_pkg::entry_t head,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = $clog2(mbc1_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(mbc1_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(mbc1_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(mbc1_pkg::QUEUE_DEPTH);

	mbc1_pkg::entry_t   slot_q [mbc1_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = (count_q == CNT_MAX);
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`MBC1_ASSERT_NEVER(a_q_overflow, clk, arst_n, push && full && !pop)
	`MBC1_ASSERT_NEVER(a_q_underflow, clk, arst_n, pop && empty)
	`MBC1_ASSERT_NXT(a_q_grow, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

// ===== hdl/mbc1_back.sv =====
// Back end: cartridge RAM access and the output register.
`include "mbc1_bank_mapper_unit_assert.svh"
module mbc1_back #(
	parameter int RAM_BYTES = mbc1_pkg::RAM_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  mbc1_pkg::entry_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       read_data,
	output logic [20:0]      rom_address,
	output logic             rom_read,
	output logic             ram_enabled
);

	localparam int AW = $clog2(RAM_BYTES);

	logic [7:0]       ram_mem [RAM_BYTES];
	logic [7:0]       rd_data_q;
	mbc1_pkg::entry_t out_q;
	logic             out_valid_q;
	logic [AW-1:0]    ram_idx;

	assign ram_idx = head.ram_pos[AW-1:0];
	assign pop     = !q_empty && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (pop && head.ram_wr) begin
			ram_mem[ram_idx] <= head.wr_data;
		end
		if (pop && head.ram_rd) begin
			rd_data_q <= ram_mem[ram_idx];
		end
		if (pop) begin
			out_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = out_q.ram_rd ? rd_data_q : out_q.fixed_data;
	assign rom_address = out_q.rom_address;
	assign rom_read    = out_q.rom_read;
	assign ram_enabled = out_q.ram_enabled;

	`MBC1_ASSERT_IMP(a_no_pop_stalled, clk, arst_n, out_valid_q && !out_ready, !pop)

endmodule

// ===== hdl/mbc1_bank_mapper_unit.sv =====
// Top level of the MBC1 bank mapper: front end, queue and back end.
// Latency: a result passes through a queue slot and then the output register, and waits while out_ready is low.
// Throughput: one access per clock while out_ready is high, held by the two-entry queue and the output register.
// Cart RAM is one write/read port with registered read data, used once per access.
// Async reset clears bank, mode, enable, size and queue state; cart RAM is not cleared.
module mbc1_bank_mapper_unit #(
	parameter int RAM_BYTES = mbc1_pkg::RAM_BYTES_DEF,
	parameter int ROM_BANKS = mbc1_pkg::ROM_BANKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_enable,
	input  logic [1:0]  cfg_write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic [20:0] rom_address,
	output logic        rom_read,
	output logic        ram_enabled
);

	mbc1_pkg::entry_t push_entry;
	mbc1_pkg::entry_t head;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;

	mbc1_front #(
		.RAM_BYTES(RAM_BYTES),
		.ROM_BANKS(ROM_BANKS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_write_data   (cfg_write_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.action           (action),
		.address          (address),
		.write_data       (write_data),
		.q_full           (q_full),
		.push             (push),
		.entry            (push_entry)
	);

	mbc1_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	mbc1_back #(
		.RAM_BYTES(RAM_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_data   (read_data),
		.rom_address (rom_address),
		.rom_read    (rom_read),
		.ram_enabled (ram_enabled)
	);

endmodule
